// ===== rtl/core/rfa_pkg.sv =====
// Shared types and constants for the RTP H.264 FU-A packetizer.
// No dependencies; imported by every module of the block.
package rfa_pkg;

    localparam int DEF_MAX_NAL_BYTES = 16384;

    // fixed field widths
    localparam int NAL_LEN_W  = 15;
    localparam int PKT_LEN_W  = 12;
    localparam int OFF_OUT_W  = 14;
    localparam int SEQ_W      = 16;
    localparam int TS_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 104;

    // header sizes in bytes, packet size limits and FU-A constants
    localparam logic [PKT_LEN_W-1:0] RTP_HDR_BYTES = 12'd12;
    localparam logic [PKT_LEN_W-1:0] FU_HDR_BYTES  = 12'd2;
    localparam logic [PKT_LEN_W-1:0] TCP_HDR_BYTES = 12'd4;
    localparam logic [PKT_LEN_W-1:0] MAXP_MIN      = 12'd512;
    localparam logic [PKT_LEN_W-1:0] MAXP_MAX      = 12'd2048;
    localparam logic [4:0]           FU_A_TYPE     = 5'd28;
    localparam logic [7:0]           NRI_F_MASK    = 8'hE0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TCP_INTERLEAVED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC_VALUE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_KIND     = 2'd3;

    // configuration reset values
    localparam logic [PKT_LEN_W-1:0] RST_MAX_PACKET_BYTES = 12'd1400;
    localparam logic [6:0]           RST_PAYLOAD_KIND     = 7'd96;

    typedef struct packed {
        logic load;   // capture a new NAL descriptor
        logic emit;   // produce the next packet descriptor
    } rfa_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a descriptor this cycle
        logic last;      // packet being built is the last of the NAL
    } rfa_status_t;

endpackage

// ===== rtl/core/rfa_ctrl.sv =====
// Controller FSM for the FU-A packetizer: NAL acceptance and packet emission.
// Depends on rfa_pkg.
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_len_zero,
    output logic        in_ready,
    input  rfa_status_t status,
    output rfa_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                // zero-length NAL is consumed without output
                if (in_valid && !in_len_zero) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/rfa_dp.sv =====
// Datapath for the FU-A packetizer: fragment bookkeeping, sequence counter
// and output register. Depends on rfa_pkg; driven by rfa_ctrl commands.
module rfa_dp
    import rfa_pkg::*;
#(
    parameter int MAX_NAL_BYTES = DEF_MAX_NAL_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rfa_cmd_t              cmd,
    output rfa_status_t           status,
    input  logic [NAL_LEN_W-1:0]  in_nal_length,
    input  logic [7:0]            in_nal_header,
    input  logic [TS_W-1:0]       in_timestamp,
    input  logic                  cfg_tcp,
    input  logic [PKT_LEN_W-1:0]  cfg_maxp,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [SEQ_W-1:0]      o_seq_number,
    output logic                  o_marker,
    output logic                  o_fragmented,
    output logic [7:0]            o_fu_indicator,
    output logic [7:0]            o_fu_header,
    output logic [OFF_OUT_W-1:0]  o_payload_offset,
    output logic [PKT_LEN_W-1:0]  o_payload_length,
    output logic [PKT_LEN_W-1:0]  o_interleave_length,
    output logic [TS_W-1:0]       o_packet_timestamp
);

    localparam int LEN_W = $clog2(MAX_NAL_BYTES + 1);
    localparam int CMP_W = 16;

    // per-NAL state
    logic [LEN_W-1:0]     left_reg, off_reg;
    logic [PKT_LEN_W-1:0] chunk_reg;
    logic                 tcp_reg, single_reg, first_reg;
    logic [7:0]           ind_reg;
    logic [4:0]           typ_reg;
    logic [TS_W-1:0]      ts_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic                 m_tvalid_reg;

    // load-time values
    logic [LEN_W-1:0]     len_clamp;
    logic [PKT_LEN_W-1:0] maxp_sat, tcp_bytes, chunk_load;
    logic                 single_load;

    // emit-time values
    logic                 last;
    logic [PKT_LEN_W-1:0] d, hdr_bytes;
    logic [SEQ_W-1:0]     seq_next;

    always_comb begin
        len_clamp = (in_nal_length > NAL_LEN_W'(MAX_NAL_BYTES)) ?
                    LEN_W'(MAX_NAL_BYTES) : LEN_W'(in_nal_length);
        priority if (cfg_maxp < MAXP_MIN) begin
            maxp_sat = MAXP_MIN;
        end else if (cfg_maxp > MAXP_MAX) begin
            maxp_sat = MAXP_MAX;
        end else begin
            maxp_sat = cfg_maxp;
        end
        tcp_bytes   = cfg_tcp ? TCP_HDR_BYTES : '0;
        // largest FU-A payload
        chunk_load  = maxp_sat - tcp_bytes - RTP_HDR_BYTES - FU_HDR_BYTES;
        // fits as a single NAL packet: len + tcp + 12 <= maxp
        single_load = CMP_W'(len_clamp) <= (CMP_W'(chunk_load) + CMP_W'(FU_HDR_BYTES));
    end

    always_comb begin
        last      = single_reg || (CMP_W'(left_reg) <= CMP_W'(chunk_reg));
        d         = last ? PKT_LEN_W'(left_reg) : chunk_reg;
        hdr_bytes = single_reg ? RTP_HDR_BYTES : (RTP_HDR_BYTES + FU_HDR_BYTES);
        seq_next  = seq_reg + SEQ_W'(1);
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.last     = last;
    assign m_tvalid        = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                seq_reg      <= seq_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            // FU-A fragments skip the NAL header byte
            left_reg   <= single_load ? len_clamp : (len_clamp - LEN_W'(1));
            off_reg    <= single_load ? '0 : LEN_W'(1);
            chunk_reg  <= chunk_load;
            tcp_reg    <= cfg_tcp;
            single_reg <= single_load;
            first_reg  <= 1'b1;
            ind_reg    <= (in_nal_header & NRI_F_MASK) | {3'b000, FU_A_TYPE};
            typ_reg    <= in_nal_header[4:0];
            ts_reg     <= in_timestamp;
        end else if (cmd.emit) begin
            left_reg  <= left_reg - LEN_W'(d);
            off_reg   <= off_reg + LEN_W'(d);
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            o_seq_number        <= seq_next;
            o_marker            <= last;
            o_fragmented        <= !single_reg;
            o_fu_indicator      <= single_reg ? 8'h00 : ind_reg;
            o_fu_header         <= single_reg ? 8'h00 : {first_reg, last, 1'b0, typ_reg};
            o_payload_offset    <= OFF_OUT_W'(off_reg);
            o_payload_length    <= d;
            o_interleave_length <= tcp_reg ? (d + hdr_bytes) : '0;
            o_packet_timestamp  <= ts_reg;
        end
    end

endmodule

// ===== rtl/core/rtp_h264_fu_a_packetizer.sv =====
// RTP H.264 packetizer, descriptor level. Each input transaction describes one
// NAL unit (length, header byte, timestamp); the block emits one descriptor per
// RTP packet: a single-NAL packet when the NAL fits in max_packet_bytes, else
// FU-A fragments with m_tlast (RTP marker) on the last one. The input is taken
// when idle; the block then emits one packet descriptor per cycle while the
// output is not stalled, through a one-entry output register, and takes no
// new NAL until the current one has sent all its packets (up to 34 at the
// smallest packet size). A zero-length NAL is consumed with no output. The
// sequence counter starts at 0 after reset and the first packet carries 1.
// Configuration writes are accepted on every cycle and must be issued only
// while the block is idle. Depends on rfa_pkg, rfa_ctrl and rfa_dp.
module rtp_h264_fu_a_packetizer
    import rfa_pkg::*;
#(
    parameter int MAX_NAL_BYTES = DEF_MAX_NAL_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [14:0] nal_length, [22:15] nal_header, [54:23] timestamp, [55] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] seq_number, [23:16] fu_indicator, [31:24] fu_header,
    // [45:32] payload_offset, [57:46] payload_length,
    // [69:58] interleave_length, [101:70] packet_timestamp, [103:102] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,   // marker
    output logic                   m_tuser,   // [0] fragmented
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                  tcp_interleaved_reg;
    logic [PKT_LEN_W-1:0]  max_packet_bytes_reg;
    logic [31:0]           ssrc_value_reg;      // held for the header builder
    logic [6:0]            payload_kind_reg;    // held for the header builder

    rfa_cmd_t              cmd;
    rfa_status_t           status;

    logic [SEQ_W-1:0]      seq_number;
    logic [7:0]            fu_indicator, fu_header;
    logic [OFF_OUT_W-1:0]  payload_offset;
    logic [PKT_LEN_W-1:0]  payload_length, interleave_length;
    logic [TS_W-1:0]       packet_timestamp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcp_interleaved_reg  <= 1'b0;
            max_packet_bytes_reg <= RST_MAX_PACKET_BYTES;
            ssrc_value_reg       <= '0;
            payload_kind_reg     <= RST_PAYLOAD_KIND;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TCP_INTERLEAVED:  tcp_interleaved_reg  <= cfg_data[0];
                CFG_MAX_PACKET_BYTES: max_packet_bytes_reg <= cfg_data[PKT_LEN_W-1:0];
                CFG_SSRC_VALUE:       ssrc_value_reg       <= cfg_data;
                CFG_PAYLOAD_KIND:     payload_kind_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rfa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_len_zero (s_tdata[NAL_LEN_W-1:0] == '0),
        .in_ready    (s_tready),
        .status      (status),
        .cmd         (cmd)
    );

    rfa_dp #(
        .MAX_NAL_BYTES (MAX_NAL_BYTES)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .in_nal_length       (s_tdata[14:0]),
        .in_nal_header       (s_tdata[22:15]),
        .in_timestamp        (s_tdata[54:23]),
        .cfg_tcp             (tcp_interleaved_reg),
        .cfg_maxp            (max_packet_bytes_reg),
        .m_tready            (m_tready),
        .m_tvalid            (m_tvalid),
        .o_seq_number        (seq_number),
        .o_marker            (m_tlast),
        .o_fragmented        (m_tuser),
        .o_fu_indicator      (fu_indicator),
        .o_fu_header         (fu_header),
        .o_payload_offset    (payload_offset),
        .o_payload_length    (payload_length),
        .o_interleave_length (interleave_length),
        .o_packet_timestamp  (packet_timestamp)
    );

    assign m_tdata = {2'b00, packet_timestamp, interleave_length, payload_length,
                      payload_offset, fu_header, fu_indicator, seq_number};

    // a non-final fragment leaving means the NAL is still in progress
    a_busy_midrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("input ready while a NAL is still being fragmented");

    // single-NAL packets always close the NAL
    a_single_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("single NAL packet without marker");

    // a start fragment is never the final fragment
    a_start_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tdata[31]) |-> (!m_tlast && !m_tdata[30]))
        else $error("FU-A start fragment also flagged as end");

    // every emit command lands in the output register
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted descriptor not presented");

endmodule

// ===== bench/rtp_h264_fu_a_packetizer_test.sv =====
// Self-checking bench for rtp_h264_fu_a_packetizer: drives NAL descriptors, predicts
// every RTP packet descriptor and checks m_tdata, m_tlast and m_tuser in order.
// Depends on rfa_pkg and the packetizer RTL; needs no files or arguments.
module rtp_h264_fu_a_packetizer_test;
    import rfa_pkg::*;

    localparam int NAL_MAX     = DEF_MAX_NAL_BYTES;
    localparam int MAX_FRAGS   = 34;
    // worst quiet stretch is the receiver hold-off; keep a wide margin
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        logic [SEQ_W-1:0]     seq;
        logic                 marker;
        logic                 frag;
        logic [7:0]           fu_ind;
        logic [7:0]           fu_hdr;
        logic [OFF_OUT_W-1:0] offset;
        logic [PKT_LEN_W-1:0] pay_len;
        logic [PKT_LEN_W-1:0] ilv_len;
        logic [TS_W-1:0]      ts;
    } rtp_pkt_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the block's registers and sequence counter
    logic                  cfg_tcp  = 1'b0;
    logic [PKT_LEN_W-1:0]  cfg_maxp = RST_MAX_PACKET_BYTES;
    logic [31:0]           cfg_ssrc = '0;
    logic [6:0]            cfg_pt   = RST_PAYLOAD_KIND;
    logic [SEQ_W-1:0]      seq_count = '0;

    rtp_pkt_t    pkt_expect_q[$];
    rtp_pkt_t    exp_pkt;
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;
    int          rx_hold_req = 0;
    int          rx_hold_left = 0;

    rtp_h264_fu_a_packetizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Packet descriptors for one NAL, appended to the expectation queue.
    function automatic void predict_packets(input logic [NAL_LEN_W-1:0] nal_len,
                                            input logic [7:0] nal_hdr,
                                            input logic [TS_W-1:0] ts);
        int unsigned len, maxp, ilv, chunk, left, off, d, n;
        rtp_pkt_t p;
        len = nal_len;
        if (len == 0)
            return;
        if (len > NAL_MAX)
            len = NAL_MAX;
        maxp = cfg_maxp;
        if (maxp < MAXP_MIN)
            maxp = MAXP_MIN;
        if (maxp > MAXP_MAX)
            maxp = MAXP_MAX;
        ilv = cfg_tcp ? TCP_HDR_BYTES : 0;
        p.ts = ts;
        if (len + ilv + RTP_HDR_BYTES <= maxp) begin
            seq_count++;
            p.seq     = seq_count;
            p.marker  = 1'b1;
            p.frag    = 1'b0;
            p.fu_ind  = '0;
            p.fu_hdr  = '0;
            p.offset  = '0;
            p.pay_len = PKT_LEN_W'(len);
            p.ilv_len = cfg_tcp ? PKT_LEN_W'(len + RTP_HDR_BYTES) : '0;
            pkt_expect_q.push_back(p);
            return;
        end
        // FU-A: NAL header byte is dropped, payload starts at offset 1
        chunk = maxp - ilv - RTP_HDR_BYTES - FU_HDR_BYTES;
        left  = len - 1;
        off   = 1;
        n     = 0;
        while (left > 0 && n < MAX_FRAGS) begin
            seq_count++;
            if (left + ilv + RTP_HDR_BYTES + FU_HDR_BYTES <= maxp) begin
                p.marker = 1'b1;
                d = left;
            end else begin
                p.marker = 1'b0;
                d = chunk;
            end
            p.seq     = seq_count;
            p.frag    = 1'b1;
            p.fu_ind  = (nal_hdr & NRI_F_MASK) | FU_A_TYPE;
            p.fu_hdr  = {(n == 0), p.marker, 1'b0, nal_hdr[4:0]};
            p.offset  = OFF_OUT_W'(off);
            p.pay_len = PKT_LEN_W'(d);
            p.ilv_len = cfg_tcp ? PKT_LEN_W'(d + RTP_HDR_BYTES + FU_HDR_BYTES) : '0;
            pkt_expect_q.push_back(p);
            left -= d;
            off  += d;
            n++;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pkt_expect_q.size() == 0) begin
                $display("%0t: unexpected packet: expected none, actual tdata %h",
                         $time, m_tdata);
                errors++;
            end else begin
                exp_pkt = pkt_expect_q.pop_front();
                check_field("seq_number", exp_pkt.seq, m_tdata[15:0]);
                check_field("marker", exp_pkt.marker, m_tlast);
                check_field("fragmented", exp_pkt.frag, m_tuser);
                check_field("fu_indicator", exp_pkt.fu_ind, m_tdata[23:16]);
                check_field("fu_header", exp_pkt.fu_hdr, m_tdata[31:24]);
                check_field("payload_offset", exp_pkt.offset, m_tdata[45:32]);
                check_field("payload_length", exp_pkt.pay_len, m_tdata[57:46]);
                check_field("interleave_length", exp_pkt.ilv_len, m_tdata[69:58]);
                check_field("packet_timestamp", exp_pkt.ts, m_tdata[101:70]);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("rtp_h264_fu_a_packetizer_test NOT OK");
            $finish;
        end
    end

    // Offer one NAL descriptor; valid stays high afterwards for back-to-back items.
    task automatic send_nal(input logic [NAL_LEN_W-1:0] nal_len, input logic [7:0] nal_hdr,
                            input logic [TS_W-1:0] ts);
        if (!no_idle && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ts, nal_hdr, nal_len};
        do @(posedge aclk); while (!s_tready);
        predict_packets(nal_len, nal_hdr, ts);
    endtask

    task automatic send_random_nal();
        int unsigned pick;
        logic [NAL_LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 4)
            len = 0;
        else if (pick < 8)
            len = NAL_LEN_W'($urandom_range(32767, NAL_MAX + 1));
        else if (pick < 40)
            len = NAL_LEN_W'($urandom_range(600, 1));
        else if (pick < 75)
            len = NAL_LEN_W'($urandom_range(4000, 600));
        else if (pick < 92)
            len = NAL_LEN_W'($urandom_range(NAL_MAX, 4000));
        else
            len = NAL_LEN_W'($urandom);
        send_nal(len, 8'($urandom), $urandom);
    endtask

    // Stop offering and wait until every expected packet has come out.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pkt_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic tcp, input logic [31:0] maxp,
                              input logic [31:0] ssrc, input logic [31:0] pt);
        logic [CFG_DATA_W-1:0] val [4];
        val[CFG_TCP_INTERLEAVED]  = {31'($urandom), tcp};
        val[CFG_MAX_PACKET_BYTES] = maxp;
        val[CFG_SSRC_VALUE]       = ssrc;
        val[CFG_PAYLOAD_KIND]     = pt;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_tcp  = val[CFG_TCP_INTERLEAVED][0];
        cfg_maxp = val[CFG_MAX_PACKET_BYTES][PKT_LEN_W-1:0];
        cfg_ssrc = val[CFG_SSRC_VALUE];
        cfg_pt   = val[CFG_PAYLOAD_KIND][6:0];
    endtask

    // reset settings: single/fragment boundaries, empty and oversized NALs
    task automatic test_reset_defaults();
        send_nal(1, 8'h00, 32'h0000_0000);
        send_nal(1388, 8'hFF, 32'hFFFF_FFFF);   // exactly fills 1400
        send_nal(1389, 8'h65, 32'h0000_0001);   // one byte too many
        send_nal(0, 8'hA5, 32'h1234_5678);      // empty NAL
        send_nal(2773, 8'h9F, 32'h8000_0000);   // last fragment exactly full
        send_nal(NAL_MAX, 8'h41, 32'h7FFF_FFFF);
        send_nal(NAL_MAX + 1, 8'h7C, 32'hDEAD_BEEF);
        send_nal(15'h7FFF, 8'h1F, 32'h5A5A_5A5A);
        wait_drain();
    endtask

    task automatic test_config_extremes();
        set_config(1'b1, 512, 32'hFFFF_FFFF, 127);
        send_nal(496, 8'h65, 32'hFFFF_FFFF);
        send_nal(497, 8'hE1, 32'h0);
        send_nal(NAL_MAX, 8'h05, 32'h0102_0304);   // most fragments
        wait_drain();
        set_config(1'b0, 100, 32'h0, 0);           // below range, used as 512
        send_nal(500, 8'h67, 32'h11);
        send_nal(501, 8'h68, 32'h22);
        wait_drain();
        set_config(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 96);   // above range, used as 2048
        send_nal(2032, 8'h06, 32'h33);
        send_nal(2033, 8'hC7, 32'h44);
        send_nal(NAL_MAX, 8'h25, 32'h55);
        wait_drain();
        set_config(1'b0, 2048, 32'h8765_4321, 0);
        send_nal(2036, 8'h21, 32'h66);
        send_nal(2037, 8'h3E, 32'h77);
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        set_config(1'b1, 600, $urandom, $urandom_range(127));
        rx_hold_req = 300;
        repeat (12)
            send_nal(NAL_LEN_W'($urandom_range(6000, 1500)), 8'($urandom), $urandom);
        wait_drain();   // sender holds until every packet is out
        repeat (8)
            send_random_nal();
        wait_drain();
    endtask

    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        repeat (20)
            send_random_nal();
        wait_drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        logic [31:0] maxp;
        repeat (4) begin
            pick = $urandom_range(4);
            case (pick)
                0: maxp = 512;
                1: maxp = 2048;
                2: maxp = $urandom_range(511);
                3: maxp = $urandom;
                default: maxp = $urandom_range(2048, 512);
            endcase
            set_config(1'($urandom_range(1)), maxp, $urandom, $urandom);
            repeat (40)
                send_random_nal();
            wait_drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_output_backpressure();
        test_no_idle_stretch();
        test_random_traffic();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("rtp_h264_fu_a_packetizer_test OK");
        else
            $display("rtp_h264_fu_a_packetizer_test NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rfa_pkg.sv
rtl/core/rfa_ctrl.sv
rtl/core/rfa_dp.sv
rtl/core/rtp_h264_fu_a_packetizer.sv
bench/rtp_h264_fu_a_packetizer_test.sv
